### sv/adaptive_clutter_map_filter_macros.svh
// ----------------------------------------------------------------------------
// Adaptive clutter map filter: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_CLUTTER_MAP_FILTER_MACROS_SVH
`define ADAPTIVE_CLUTTER_MAP_FILTER_MACROS_SVH

`ifndef SYNTH

`define ACMF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("acmf: assertion failed");

`define ACMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acmf: assertion failed");

`else

`define ACMF_ASSERT(label, clk, rst, prop)

`define ACMF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### sv/acmf_pkg.sv
// ----------------------------------------------------------------------------
// acmf_pkg
// Shared constants, types and helpers of the adaptive clutter map filter.
// ----------------------------------------------------------------------------
`default_nettype none

package acmf_pkg;

   localparam int SampleWidth   = 24;
   localparam int MaxBins       = 512;
   localparam int BinWidth      = $clog2(MaxBins);
   localparam int MaxSpread     = 8;
   localparam int SpreadWidth   = 4;
   localparam int TapCount      = 2 * MaxSpread + 1;
   localparam int LagWidth      = $clog2(MaxSpread + 1);
   localparam int OffWidth      = $clog2(TapCount);
   localparam int GroupSize     = 6;
   localparam int GroupCount    = (TapCount + GroupSize - 1) / GroupSize;
   localparam int FactorWidth   = 16;
   localparam int FracBits      = 15;
   localparam int OneQ15        = 1 << FracBits;
   localparam int HalfQ15       = OneQ15 / 2;
   localparam int LengthWidth   = 10;
   localparam int ProdWidth     = SampleWidth + FactorWidth + 2;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CsrAdaptFactor = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSpread      = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrFrameLength = 2'd2;

   localparam logic [FactorWidth-1:0] FactorReset = 16'd1638;
   localparam logic [SpreadWidth-1:0] SpreadReset = 4'd2;
   localparam logic [LengthWidth-1:0] LengthReset = 10'd512;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic [BinWidth-1:0]           bin_type;

   localparam sample_type SampleMax = {1'b0, {(SampleWidth-1){1'b1}}};
   localparam sample_type SampleMin = {1'b1, {(SampleWidth-1){1'b0}}};

   typedef struct packed {
      sample_type residual;
      bin_type    bin;
      logic       frame_end;
   } push_type;

   typedef struct packed {
      sample_type residual;
      bin_type    bin_index;
      logic       frame_last;
   } result_type;

   function automatic sample_type sat_sample(input logic signed [SampleWidth:0] v);
      sample_type res;
      if (v[SampleWidth] != v[SampleWidth-1]) begin
         res = v[SampleWidth] ? SampleMin : SampleMax;
      end else begin
         res = v[SampleWidth-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### sv/acmf_req_if.sv
// ----------------------------------------------------------------------------
// acmf_req_if
// Request channel: one raw range-bin amplitude per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface acmf_req_if;
   import acmf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type amplitude;

   modport source (output valid, output amplitude, input ready);
   modport sink   (input valid, input amplitude, output ready);
endinterface

`default_nettype wire

### sv/acmf_rsp_if.sv
// ----------------------------------------------------------------------------
// acmf_rsp_if
// Result channel: window-maximum residual with its bin and frame marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface acmf_rsp_if;
   import acmf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type residual;
   bin_type    bin_index;
   logic       frame_last;

   modport source (output valid, output residual, output bin_index, output frame_last,
                   input ready);
   modport sink   (input valid, input residual, input bin_index, input frame_last,
                   output ready);
endinterface

`default_nettype wire

### sv/acmf_ram.sv
// ----------------------------------------------------------------------------
// acmf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module acmf_ram #(
   parameter int Width = 24,
   parameter int Depth = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/acmf_window.sv
// ----------------------------------------------------------------------------
// acmf_window
// Residual tap line and window-maximum emitter with output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acmf_window (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [acmf_pkg::SpreadWidth-1:0] spread_eff,
   input  wire logic                           push_valid,
   input  wire acmf_pkg::push_type             push_item,
   output logic                                push_ok,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output acmf_pkg::result_type                rsp_item
);
   import acmf_pkg::*;

   sample_type taps_ff [TapCount];
   bin_type    last_bin_ff, last_bin_in;
   bin_type    out_bin_ff, out_bin_in;
   logic       active_ff, active_in;
   logic       flush_ff, flush_in;

   logic       e1_valid_ff;
   sample_type e1_part_ff [GroupCount];
   sample_type part [GroupCount];
   bin_type    e1_bin_ff;
   logic       e1_last_ff;

   logic       rsp_valid_ff;
   result_type rsp_item_ff, rsp_item_in;

   logic                    en, due, more_due, is_final, emit, push;
   logic [BinWidth:0]       reach;
   bin_type                 lag_full;
   logic [LagWidth-1:0]     lag;
   logic [OffWidth-1:0]     lo_off, hi_off, hi_sum;

   assign en       = !rsp_valid_ff || rsp_ready;
   assign reach    = (BinWidth+1)'(out_bin_ff) + (BinWidth+1)'(spread_eff);
   assign is_final = flush_ff && (out_bin_ff == last_bin_ff);
   assign due      = active_ff && (flush_ff || reach <= (BinWidth+1)'(last_bin_ff));
   assign more_due = flush_ff ? !is_final
                              : (reach + (BinWidth+1)'(1)) <= (BinWidth+1)'(last_bin_ff);
   assign emit     = en && due;
   assign push_ok  = en && (!due || !more_due);
   assign push     = push_valid && push_ok;

   // window bounds as offsets back from the newest tap
   assign lag_full = last_bin_ff - out_bin_ff;
   assign lag      = lag_full[LagWidth-1:0];
   assign hi_sum   = OffWidth'(lag) + OffWidth'(spread_eff);

   always_comb begin
      if (OffWidth'(lag) > OffWidth'(spread_eff)) begin
         lo_off = OffWidth'(lag) - OffWidth'(spread_eff);
      end else begin
         lo_off = '0;
      end
      if (BinWidth'(hi_sum) > last_bin_ff) begin
         hi_off = OffWidth'(last_bin_ff);
      end else begin
         hi_off = hi_sum;
      end
   end

   always_comb begin
      sample_type v;
      v = SampleMin;
      for (int g = 0; g < GroupCount; g++) begin
         part[g] = SampleMin;
         for (int k = 0; k < GroupSize; k++) begin
            if (g * GroupSize + k < TapCount) begin
               if (OffWidth'(g * GroupSize + k) >= lo_off &&
                   OffWidth'(g * GroupSize + k) <= hi_off) begin
                  v = taps_ff[g * GroupSize + k];
               end else begin
                  v = SampleMin;
               end
               if (v > part[g]) begin
                  part[g] = v;
               end
            end
         end
      end
   end

   always_comb begin
      out_bin_in  = out_bin_ff;
      active_in   = active_ff;
      flush_in    = flush_ff;
      last_bin_in = last_bin_ff;
      if (emit) begin
         out_bin_in = is_final ? '0 : out_bin_ff + BinWidth'(1);
         if (is_final) begin
            active_in = 1'b0;
            flush_in  = 1'b0;
         end
      end
      if (push) begin
         active_in   = 1'b1;
         flush_in    = push_item.frame_end;
         last_bin_in = push_item.bin;
      end
   end

   always_comb begin
      rsp_item_in.residual = e1_part_ff[0];
      for (int g = 1; g < GroupCount; g++) begin
         if (e1_part_ff[g] > rsp_item_in.residual) begin
            rsp_item_in.residual = e1_part_ff[g];
         end
      end
      rsp_item_in.bin_index  = e1_bin_ff;
      rsp_item_in.frame_last = e1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_bin_ff   <= '0;
         last_bin_ff  <= '0;
         active_ff    <= 1'b0;
         flush_ff     <= 1'b0;
         e1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         out_bin_ff   <= out_bin_in;
         last_bin_ff  <= last_bin_in;
         active_ff    <= active_in;
         flush_ff     <= flush_in;
         e1_valid_ff  <= due;
         rsp_valid_ff <= e1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         taps_ff[0] <= push_item.residual;
         for (int t = 1; t < TapCount; t++) begin
            taps_ff[t] <= taps_ff[t-1];
         end
      end
      if (en) begin
         e1_part_ff  <= part;
         e1_bin_ff   <= out_bin_ff;
         e1_last_ff  <= is_final;
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

### sv/adaptive_clutter_map_filter.sv
// ----------------------------------------------------------------------------
// adaptive_clutter_map_filter
// Per-bin exponential clutter map with window-maximum residual output.
// ----------------------------------------------------------------------------
// Requests carry one range-bin amplitude each, bins in order, frames of
// frame_length bins. Each request yields the clutter-removed residual of a
// bin, replaced by the maximum over +-spread neighbouring bins, on the
// result channel; results trail requests by spread bins and the tail of a
// frame is flushed after its last bin, marked by frame_last.
// Throughput is one request per cycle unless a hazard or stall holds it.
// The map lives in a 512-entry RAM with a read-modify-write pipeline of a
// read and an update stage; a request whose bin is still in it (frames of
// one or two bins) waits. The frame-end flush emits one result per cycle
// unless the receiver stalls, holding requests meanwhile. A request
// passes the map stages, window taps and window registers to its result.
// Reset restores the register defaults and starts a loading frame that fills
// the map and gives zero residuals; no clearing pass is needed. When the
// result receiver stalls, the output register holds and the pipeline backs up
// to the request channel after at most two further requests. The user must
// write csr_ adapt_factor, spread, frame_length only while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adaptive_clutter_map_filter_macros.svh"

module adaptive_clutter_map_filter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [acmf_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [acmf_pkg::CsrDataWidth-1:0]  csr_write_data,
   acmf_req_if.sink                             req_chan,
   acmf_rsp_if.source                           rsp_chan
);
   import acmf_pkg::*;

   // configuration
   logic [FactorWidth-1:0] factor_ff, factor_in;
   logic [SpreadWidth-1:0] spread_ff, spread_in;
   logic [LengthWidth-1:0] length_ff, length_in;
   logic [FactorWidth-1:0] factor_eff;
   logic [SpreadWidth-1:0] spread_eff;
   logic [LengthWidth-1:0] length_eff;

   // front end
   bin_type in_bin_ff, in_bin_in;
   logic    loaded_ff, loaded_in;
   logic    frame_end, req_take, req_ready, hazard, s1_adv, push_ok, push_take;

   // map read stage
   logic       s1_valid_ff, s1_valid_in;
   bin_type    s1_bin_ff;
   sample_type s1_x_ff;
   logic       s1_load_ff, s1_fe_ff;
   sample_type map_rd_data;
   logic signed [SampleWidth:0]   diff;
   logic signed [FactorWidth:0]   factor_s;
   logic signed [ProdWidth-1:0]   prod;

   // map update stage
   logic       s2_valid_ff, s2_valid_in;
   logic signed [ProdWidth-1:0]   s2_prod_ff;
   sample_type s2_m_ff, s2_x_ff;
   bin_type    s2_bin_ff;
   logic       s2_load_ff, s2_fe_ff;
   logic signed [ProdWidth-1:0]   rnd;
   logic signed [SampleWidth+1:0] msum;
   sample_type m_new;
   logic signed [SampleWidth:0]   r_full;

   push_type   push_item;
   logic       rsp_valid;
   result_type rsp_item;

   always_comb begin
      factor_in = factor_ff;
      spread_in = spread_ff;
      length_in = length_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrAdaptFactor: factor_in = csr_write_data[FactorWidth-1:0];
            CsrSpread:      spread_in = csr_write_data[SpreadWidth-1:0];
            CsrFrameLength: length_in = csr_write_data[LengthWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FactorReset;
         spread_ff <= SpreadReset;
         length_ff <= LengthReset;
      end else begin
         factor_ff <= factor_in;
         spread_ff <= spread_in;
         length_ff <= length_in;
      end
   end

   assign factor_eff = (factor_ff > FactorWidth'(OneQ15)) ? FactorWidth'(OneQ15) : factor_ff;
   assign spread_eff = (spread_ff > SpreadWidth'(MaxSpread)) ? SpreadWidth'(MaxSpread)
                                                             : spread_ff;
   always_comb begin
      if (length_ff == '0) begin
         length_eff = LengthWidth'(1);
      end else if (length_ff > LengthWidth'(MaxBins)) begin
         length_eff = LengthWidth'(MaxBins);
      end else begin
         length_eff = length_ff;
      end
   end

   // request acceptance; bins still in flight block a new map read
   assign hazard    = (s1_valid_ff && s1_bin_ff == in_bin_ff) ||
                      (s2_valid_ff && s2_bin_ff == in_bin_ff);
   assign push_take = s2_valid_ff && push_ok;
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || push_take);
   assign req_ready = (!s1_valid_ff || s1_adv) && !hazard;
   assign req_take  = req_chan.valid && req_ready;
   assign frame_end = (LengthWidth'(in_bin_ff) + LengthWidth'(1)) >= length_eff;

   always_comb begin
      in_bin_in = in_bin_ff;
      loaded_in = loaded_ff;
      if (req_take) begin
         if (frame_end) begin
            in_bin_in = '0;
            loaded_in = 1'b1;
         end else begin
            in_bin_in = in_bin_ff + BinWidth'(1);
         end
      end
   end

   assign s1_valid_in = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_adv ? 1'b1 : (push_take ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_bin_ff   <= '0;
         loaded_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         in_bin_ff   <= in_bin_in;
         loaded_ff   <= loaded_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_bin_ff  <= in_bin_ff;
         s1_x_ff    <= req_chan.amplitude;
         s1_load_ff <= !loaded_ff;
         s1_fe_ff   <= frame_end;
      end
      if (s1_adv) begin
         s2_prod_ff <= prod;
         s2_m_ff    <= map_rd_data;
         s2_x_ff    <= s1_x_ff;
         s2_bin_ff  <= s1_bin_ff;
         s2_load_ff <= s1_load_ff;
         s2_fe_ff   <= s1_fe_ff;
      end
   end

   acmf_ram #(
      .Width (SampleWidth),
      .Depth (MaxBins)
   ) u_map (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_bin_ff),
      .wr_data (m_new),
      .rd_en   (req_take),
      .rd_addr (in_bin_ff),
      .rd_data (map_rd_data)
   );

   // m += a*(x-m), rounded half up
   assign diff     = (SampleWidth+1)'(s1_x_ff) - (SampleWidth+1)'(map_rd_data);
   assign factor_s = signed'({1'b0, factor_eff});
   assign prod     = diff * factor_s;

   assign rnd    = (s2_prod_ff + ProdWidth'(HalfQ15)) >>> FracBits;
   assign msum   = (SampleWidth+2)'(s2_m_ff) + signed'(rnd[SampleWidth+1:0]);
   assign m_new  = s2_load_ff ? s2_x_ff : msum[SampleWidth-1:0];
   assign r_full = (SampleWidth+1)'(s2_x_ff) - (SampleWidth+1)'(m_new);

   assign push_item.residual  = s2_load_ff ? '0 : sat_sample(r_full);
   assign push_item.bin       = s2_bin_ff;
   assign push_item.frame_end = s2_fe_ff;

   acmf_window u_window (
      .clock      (clock),
      .reset      (reset),
      .spread_eff (spread_eff),
      .push_valid (s2_valid_ff),
      .push_item  (push_item),
      .push_ok    (push_ok),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.residual   = rsp_item.residual;
   assign rsp_chan.bin_index  = rsp_item.bin_index;
   assign rsp_chan.frame_last = rsp_item.frame_last;

   `ACMF_ASSERT(a_map_no_rw_collision, clock, reset, !(req_take && s2_valid_ff && in_bin_ff == s2_bin_ff))
   `ACMF_ASSERT_NEXT(a_s2_holds, clock, reset, s2_valid_ff && !push_take, s2_valid_ff && $stable(s2_bin_ff))
   `ACMF_ASSERT_NEXT(a_take_enters_s1, clock, reset, req_take, s1_valid_ff && s1_bin_ff == $past(in_bin_ff))

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: adaptive clutter map filter testbench
// Streams range-bin frames into the filter and checks every result against
// an in-bench model of the clutter map, residual saturation and the
// window-maximum stage. Directed frames cover the loading frame, register
// defaults and clamps, saturation and mid-frame register changes; random
// frames follow under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
   import acmf_pkg::*;

   localparam int ClockPeriod   = 10;
   localparam int ResetCycles   = 10;
   localparam int SettleCycles  = 24;
   localparam int WatchdogLimit = 2000;
   localparam int ReportLimit   = 10;
   localparam int LoadLength    = 80;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   acmf_req_if req_chan ();
   acmf_rsp_if rsp_chan ();

   adaptive_clutter_map_filter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // register copies and filter state as seen by the model
   logic [FactorWidth-1:0] factor_reg;
   logic [SpreadWidth-1:0] spread_reg;
   logic [LengthWidth-1:0] length_reg;
   longint                 clutter_est [MaxBins];
   longint                 resid_ring [TapCount];
   bit                     map_primed;
   int unsigned            in_bin;
   int unsigned            out_bin;

   result_type  due_results[$];
   int unsigned mismatch_count;
   int unsigned quiet_cycles;
   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;

   function automatic int unsigned effective_length();
      int unsigned len;
      len = 32'(length_reg);
      if (len < 1) len = 1;
      if (len > MaxBins) len = MaxBins;
      return len;
   endfunction

   function automatic sample_type window_peak(input int unsigned centre,
                                              input int unsigned s,
                                              input int unsigned top);
      int unsigned lo;
      int unsigned hi;
      int unsigned k;
      longint      best;
      lo = (centre > s) ? centre - s : 0;
      hi = (centre + s > top) ? top : centre + s;
      best = resid_ring[centre % TapCount];
      for (k = lo; k <= hi; k++) begin
         if (resid_ring[k % TapCount] > best) best = resid_ring[k % TapCount];
      end
      return sample_type'(best);
   endfunction

   function automatic void queue_result(input int unsigned bin, input int unsigned s,
                                        input int unsigned top, input bit last);
      result_type res;
      res.residual   = window_peak(bin, s, top);
      res.bin_index  = bin_type'(bin);
      res.frame_last = last;
      due_results.insert(due_results.size(), res);
   endfunction

   function automatic void predict_bin(input sample_type amp);
      longint      x;
      longint      m;
      longint      m_new;
      longint      r;
      longint      factor;
      int unsigned s;
      int unsigned len;
      int unsigned i;
      x = longint'(amp);
      factor = (factor_reg > OneQ15) ? OneQ15 : longint'(factor_reg);
      s = (spread_reg > MaxSpread) ? MaxSpread : 32'(spread_reg);
      len = effective_length();
      i = in_bin;
      r = 0;
      if (!map_primed) begin
         clutter_est[i] = x;
      end else begin
         m = clutter_est[i];
         // arithmetic shift gives floor division, rounding half up
         m_new = m + (((x - m) * factor + HalfQ15) >>> FracBits);
         clutter_est[i] = m_new;
         r = x - m_new;
         if (r > SampleMax) r = longint'(SampleMax);
         if (r < SampleMin) r = longint'(SampleMin);
      end
      resid_ring[i % TapCount] = r;
      if (i + 1 >= len) begin
         while (out_bin <= i) begin
            queue_result(out_bin, s, i, out_bin == i);
            out_bin++;
         end
         out_bin = 0;
         in_bin = 0;
         map_primed = 1'b1;
      end else begin
         while (out_bin + s <= i) begin
            queue_result(out_bin, s, i, 1'b0);
            out_bin++;
         end
         in_bin = i + 1;
      end
   endfunction

   function automatic sample_type edge_amplitude(input int unsigned bin);
      return (bin % 2 == 0) ? SampleMin : SampleMax;
   endfunction

   function automatic sample_type random_amplitude();
      case ($urandom_range(0, 9))
         0: begin
            return SampleMax;
         end
         1: begin
            return SampleMin;
         end
         2, 3, 4: begin
            return sample_type'(int'($urandom_range(0, 4000)) - 2000);
         end
         default: begin
            return sample_type'($urandom());
         end
      endcase
   endfunction

   // ---- receiver, checker, watchdog ----

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input result_type want);
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
         $display("%0t %s: expected residual %0d bin %0d last %0b, got residual %0d bin %0d last %0b",
                  $realtime, what, want.residual, want.bin_index, want.frame_last,
                  rsp_chan.residual, rsp_chan.bin_index, rsp_chan.frame_last);
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (due_results.size() == 0) begin
            want = '0;
            report_mismatch("unexpected result", want);
         end else begin
            want = due_results.pop_front();
            if (rsp_chan.residual !== want.residual || rsp_chan.bin_index !== want.bin_index
                || rsp_chan.frame_last !== want.frame_last) begin
               report_mismatch("result mismatch", want);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WatchdogLimit) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // ---- stimulus helpers ----

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CsrDataWidth'(value);
      @(posedge clock);
      case (idx)
         CsrAdaptFactor: begin
            factor_reg = FactorWidth'(value);
         end
         CsrSpread: begin
            spread_reg = SpreadWidth'(value);
         end
         CsrFrameLength: begin
            length_reg = LengthWidth'(value);
         end
         default: begin
         end
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_bin(input sample_type amp);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.amplitude <= amp;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_bin(amp);
   endtask

   // request stream paused until every due result is out and the pipe is quiet
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_random_config();
      int unsigned factor;
      int unsigned s;
      int unsigned len;
      case ($urandom_range(0, 5))
         0: factor = 0;
         1: factor = OneQ15;
         2: factor = 16'hFFFF;
         3: factor = $urandom_range(0, 16'hFFFF);
         default: factor = $urandom_range(0, OneQ15);
      endcase
      s = ($urandom_range(0, 5) == 0) ? $urandom_range(MaxSpread + 1, 15)
                                      : $urandom_range(0, MaxSpread);
      case ($urandom_range(0, 9))
         0: len = 0;
         1, 2: len = $urandom_range(25, LoadLength);
         default: len = $urandom_range(1, 24);
      endcase
      write_csr(CsrAdaptFactor, factor);
      write_csr(CsrSpread, s);
      write_csr(CsrFrameLength, len);
   endtask

   // ---- tests ----

   task automatic test_loading_frame();
      int unsigned b;
      req_idle_pct = 10;
      rsp_stall_pct = 10;
      // loads every map entry that later frames use
      write_csr(CsrFrameLength, LoadLength);
      for (b = 0; b < LoadLength; b++) begin
         send_bin((b < 4) ? edge_amplitude(b) : random_amplitude());
      end
   endtask

   task automatic test_reset_defaults();
      int unsigned b;
      hold_until_drained();
      write_csr(CsrFrameLength, 16);
      for (b = 0; b < 16; b++) begin
         send_bin((b < 4) ? edge_amplitude(b) : random_amplitude());
      end
   endtask

   task automatic test_saturation();
      int unsigned b;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_until_drained();
      write_csr(CsrAdaptFactor, 0);
      write_csr(CsrSpread, 0);
      write_csr(CsrFrameLength, 4);
      for (b = 0; b < 4; b++) send_bin(edge_amplitude(b + 1));
   endtask

   task automatic test_register_clamps();
      int unsigned b;
      hold_until_drained();
      write_csr(CsrAdaptFactor, 16'hFFFF);
      write_csr(CsrSpread, 15);
      write_csr(CsrFrameLength, 1);
      send_bin(random_amplitude());
      send_bin(random_amplitude());
      hold_until_drained();
      write_csr(CsrAdaptFactor, OneQ15);
      write_csr(CsrFrameLength, 0);
      send_bin(random_amplitude());
      send_bin(random_amplitude());
      hold_until_drained();
      // above the bin count: the frame stays open until it is shortened
      write_csr(CsrFrameLength, 1023);
      for (b = 0; b < 3; b++) send_bin(random_amplitude());
      hold_until_drained();
      write_csr(CsrFrameLength, 4);
      send_bin(random_amplitude());
   endtask

   task automatic test_midframe_changes();
      int unsigned b;
      hold_until_drained();
      write_csr(CsrAdaptFactor, HalfQ15);
      write_csr(CsrSpread, MaxSpread);
      write_csr(CsrFrameLength, 12);
      for (b = 0; b < 5; b++) send_bin(random_amplitude());
      hold_until_drained();
      write_csr(CsrSpread, 1);
      send_bin(random_amplitude());
      hold_until_drained();
      write_csr(CsrSpread, MaxSpread);
      send_bin(random_amplitude());
      hold_until_drained();
      // shrink below the current bin: next request closes the frame
      write_csr(CsrFrameLength, 4);
      send_bin(random_amplitude());
   endtask

   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned request_target);
      int unsigned sent;
      int unsigned frames;
      int unsigned f;
      int unsigned b;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < request_target) begin
         hold_until_drained();
         write_random_config();
         frames = $urandom_range(1, 4);
         for (f = 0; f < frames; f++) begin
            for (b = 0; b < effective_length(); b++) begin
               send_bin(random_amplitude());
               sent++;
               if ($urandom_range(0, 39) == 0) hold_until_drained();
            end
         end
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.amplitude = '0;
      rsp_chan.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CsrAdaptFactor;
      csr_write_data = '0;
      factor_reg = FactorReset;
      spread_reg = SpreadReset;
      length_reg = LengthReset;
      foreach (resid_ring[k]) resid_ring[k] = 0;
      map_primed = 1'b0;
      in_bin = 0;
      out_bin = 0;
      mismatch_count = 0;
      quiet_cycles = 0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      test_loading_frame();
      test_reset_defaults();
      test_saturation();
      test_register_clamps();
      test_midframe_changes();
      test_random_traffic(0, 0, 90);
      test_random_traffic(61, 0, 90);
      test_random_traffic(0, 61, 90);
      test_random_traffic(10, 10, 90);

      hold_until_drained();
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
